// ----- rtl/core/mfrag_pkg.sv -----
// ============================================================================
// mfrag_pkg - shared constants for the message fragmenter
// Frame geometry defaults and the fixed header and tail sizes.
// ============================================================================
package mfrag_pkg;

    // Default frame size in bytes and message length width
    localparam int FRAME_BYTES_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;

    // Header: four bytes of frame count plus one first-frame length byte
    localparam int HEAD_BYTES    = 5;
    localparam int HEAD_IDX_BITS = $clog2(HEAD_BYTES);

    // Length byte at the start of the last frame of a multi-frame message
    localparam int TAIL_BYTES = 1;

    // Input beat action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

endpackage

// ----- rtl/core/message_fragmenter.sv -----
// ============================================================================
// message_fragmenter - cuts messages into fixed-size radio frames
// Header generation, payload pass-through, last-frame length byte, padding.
// ============================================================================
//
// A start beat (action 0) opens a message of message_length bytes: the
// block emits a 5-byte header (frame count as four bytes, MSB first, then
// the first frame's payload count), and payload beats (action 1) then pass
// through one to one. Middle frames carry FRAME_BYTES raw bytes, the last
// frame of a multi-frame message starts with its own length byte, and every
// frame is zero-padded to FRAME_BYTES bytes. A start while a message is open
// pads the open frame and drops the rest of the old message; payload beats
// with no open message are swallowed without output. One output beat leaves
// per cycle while the output is not stalled. A payload beat inside a frame
// causes one output beat, a payload beat that closes a frame also causes its
// padding and length byte, a start beat causes 5 header bytes plus the
// padding of an open frame plus any padding of an empty first frame (up
// to about 2*FRAME_BYTES bytes), and a swallowed payload beat causes none.
// The sequencer fills the single output register at one beat per cycle,
// unless the output stalls. The frame count is computed when the start
// beat is accepted, by one constant-reciprocal multiply into the item
// register. The next input beat is accepted in the same cycle as the last
// output beat of the current one, and also while an earlier result waits
// on a stalled output.
//
module message_fragmenter
    import mfrag_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_message_length,
    input  logic [7:0]  i_payload_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    output logic        o_run_end
);

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    localparam int LB        = LENGTH_BITS;
    localparam int FB        = FRAME_BYTES;
    localparam int POS_BITS  = $clog2(FB);          // position 0 .. FB-1
    localparam int FPL_BITS  = $clog2(FB + 1);      // payload left 0 .. FB
    // ceil((len + HEAD + TAIL) / FB) = floor((len + HEAD + TAIL + FB - 1) / FB)
    localparam int ROUND_ADD = HEAD_BYTES + TAIL_BYTES + FB - 1;
    localparam int MAX_FRAMES = ((1 << LB) - 1 + ROUND_ADD) / FB;
    localparam int FRM_BITS  = $clog2(MAX_FRAMES + 1);
    // dividend width, and the reciprocal that makes x*RECIP >> (XB+L2) exact
    localparam int XB        = LB + 1;
    localparam int L2        = $clog2(FB);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << (XB + L2)) + longint'(FB) - 1) / longint'(FB);
    localparam logic [XB:0] RECIP = RECIP_FULL[XB:0];

    // ------------------------------------------------------------------------
    // Sequencer phases of the item in the item register
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        PH_PAD,     // start beat: pad the open frame, then header byte 0
        PH_HEAD,    // start beat: remaining header bytes
        PH_PAY,     // payload beat: its own byte
        PH_SETTLE   // padding and last-frame length byte
    } t_phase;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    // item register
    logic                     r_item_valid;
    logic [LB-1:0]            r_item_len;
    logic [7:0]               r_item_byte;
    logic [FRM_BITS-1:0]      r_item_frames;
    logic                     r_item_single;
    t_phase                   r_phase;
    logic [HEAD_IDX_BITS-1:0] r_head_idx;
    // message state
    logic                     r_open;
    logic [LB-1:0]            r_bytes_left;
    logic [FRM_BITS-1:0]      r_frames_left;
    logic [POS_BITS-1:0]      r_pos;
    logic [FPL_BITS-1:0]      r_fpl;
    // output register
    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_out_frame_end;
    logic                     r_out_run_end;

    // ------------------------------------------------------------------------
    // Frame count at accept: one multiply into the item register
    // ------------------------------------------------------------------------
    logic [31:0]         len_ext;
    logic [LB-1:0]       in_len;
    logic [XB-1:0]       div_x;
    logic [2*XB:0]       div_prod;
    logic [FRM_BITS-1:0] in_quot;
    logic                in_single;

    always_comb begin
        len_ext   = {16'h0000, i_message_length};
        in_len    = len_ext[LB-1:0];
        div_x     = XB'(in_len) + XB'(ROUND_ADD);
        div_prod  = (2*XB+1)'(div_x) * (2*XB+1)'(RECIP);
        in_quot   = div_prod[XB+L2 +: FRM_BITS];
        in_single = (in_len <= LB'(FB - HEAD_BYTES));
    end

    // ------------------------------------------------------------------------
    // One output beat per step
    // ------------------------------------------------------------------------
    logic                     advance;
    logic                     frame_end_now;
    logic [POS_BITS-1:0]      pos_next;
    logic                     pad_old;
    logic [HEAD_IDX_BITS-1:0] cur_idx;
    logic [31:0]              frames32;
    logic [31:0]              hdr_shift;
    logic [7:0]               hdr_byte;

    logic                     beat_valid;
    logic [7:0]               beat_byte;
    logic                     beat_last;
    logic                     item_drop;
    logic                     do_settle;
    logic                     need_more;

    logic                     raw_open;
    logic [LB-1:0]            raw_bl;
    logic [FRM_BITS-1:0]      raw_fl;
    logic [FPL_BITS-1:0]      raw_fpl;
    logic [POS_BITS-1:0]      raw_pos;
    t_phase                   n_phase;
    logic [HEAD_IDX_BITS-1:0] n_head_idx;

    logic                     item_done;
    logic                     step;
    logic                     in_accept;

    assign advance       = !r_out_valid || !i_stall;
    assign frame_end_now = (r_pos == POS_BITS'(FB - 1));
    assign pos_next      = frame_end_now ? '0 : r_pos + 1'b1;

    // header byte: frame count MSB first, then first-frame payload count
    always_comb begin
        pad_old   = r_open && (r_pos != '0);
        cur_idx   = (r_phase == PH_PAD) ? '0 : r_head_idx;
        frames32  = {{(32 - FRM_BITS){1'b0}}, r_item_frames};
        hdr_shift = frames32 >> {2'd3 - cur_idx[1:0], 3'b000};
        if (cur_idx == HEAD_IDX_BITS'(HEAD_BYTES - 1)) begin
            hdr_byte = r_item_single ? r_item_len[7:0] : 8'(FB - HEAD_BYTES);
        end else begin
            hdr_byte = hdr_shift[7:0];
        end
    end

    always_comb begin
        beat_valid = 1'b0;
        beat_byte  = 8'h00;
        beat_last  = 1'b0;
        item_drop  = 1'b0;
        do_settle  = 1'b0;
        need_more  = 1'b0;
        raw_open   = r_open;
        raw_bl     = r_bytes_left;
        raw_fl     = r_frames_left;
        raw_fpl    = r_fpl;
        raw_pos    = r_pos;
        n_phase    = r_phase;
        n_head_idx = r_head_idx;

        if (r_item_valid) begin
            unique case (r_phase)
                PH_PAD, PH_HEAD: begin
                    beat_valid = 1'b1;
                    if (r_phase == PH_PAD && pad_old) begin
                        beat_byte = 8'h00;
                    end else begin
                        beat_byte = hdr_byte;
                        if (cur_idx == HEAD_IDX_BITS'(HEAD_BYTES - 1)) begin
                            // header done: the new message opens
                            raw_open  = 1'b1;
                            raw_bl    = r_item_len;
                            raw_fl    = r_item_frames - 1'b1;
                            raw_fpl   = r_item_single ? r_item_len[FPL_BITS-1:0]
                                                      : FPL_BITS'(FB - HEAD_BYTES);
                            do_settle = 1'b1;
                        end else begin
                            n_phase    = PH_HEAD;
                            n_head_idx = cur_idx + 1'b1;
                        end
                    end
                end
                PH_PAY: begin
                    if (!r_open) begin
                        item_drop = 1'b1;
                    end else begin
                        beat_valid = 1'b1;
                        beat_byte  = r_item_byte;
                        raw_bl     = r_bytes_left - 1'b1;
                        raw_fpl    = r_fpl - 1'b1;
                        do_settle  = 1'b1;
                    end
                end
                PH_SETTLE: begin
                    beat_valid = 1'b1;
                    do_settle  = 1'b1;
                    if (r_pos != '0) begin
                        beat_byte = 8'h00;
                    end else begin
                        // last frame: its length byte
                        beat_byte = r_bytes_left[7:0];
                        raw_fl    = '0;
                        raw_fpl   = r_bytes_left[FPL_BITS-1:0];
                    end
                end
                default: begin
                    item_drop = 1'b1;
                end
            endcase
        end

        if (beat_valid) begin
            raw_pos = pos_next;
        end

        // settle: more beats follow only for padding or the length byte;
        // closing and opening a middle frame take no beat
        if (do_settle) begin
            need_more = raw_open && (raw_fpl == '0) &&
                        ((raw_pos != '0) || (raw_fl == FRM_BITS'(1)));
            if (need_more) begin
                n_phase = PH_SETTLE;
            end else begin
                beat_last = 1'b1;
                if (raw_open && (raw_fpl == '0)) begin
                    if (raw_fl == '0) begin
                        raw_open = 1'b0;
                        raw_bl   = '0;
                    end else begin
                        raw_fl  = raw_fl - 1'b1;
                        raw_fpl = FPL_BITS'(FB);
                    end
                end
            end
        end
    end

    assign item_done = item_drop || (advance && beat_last);
    assign step      = r_item_valid && (item_drop || advance);
    assign o_stall   = r_item_valid && !item_done;
    assign in_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid  <= 1'b0;
            r_phase       <= PH_PAD;
            r_head_idx    <= '0;
            r_open        <= 1'b0;
            r_bytes_left  <= '0;
            r_frames_left <= '0;
            r_pos         <= '0;
            r_fpl         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (step) begin
                r_open        <= raw_open;
                r_bytes_left  <= raw_bl;
                r_frames_left <= raw_fl;
                r_pos         <= raw_pos;
                r_fpl         <= raw_fpl;
            end

            // a new beat loads the sequencer; otherwise it follows the step
            if (in_accept) begin
                r_item_valid  <= 1'b1;
                r_item_len    <= in_len;
                r_item_byte   <= i_payload_byte;
                r_item_frames <= in_single ? FRM_BITS'(1) : in_quot;
                r_item_single <= in_single;
                r_phase       <= (i_action == ACT_DATA) ? PH_PAY : PH_PAD;
                r_head_idx    <= '0;
            end else begin
                if (item_done) begin
                    r_item_valid <= 1'b0;
                end
                if (step) begin
                    r_phase    <= n_phase;
                    r_head_idx <= n_head_idx;
                end
            end

            if (advance) begin
                r_out_valid     <= r_item_valid && beat_valid;
                r_out_byte      <= beat_byte;
                r_out_frame_end <= frame_end_now;
                r_out_run_end   <= beat_last;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_frame_end;
    assign o_run_end    = r_out_run_end;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    // an open message always has payload due in its current frame between items
    a_open_has_payload : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_item_valid && r_open) |-> (r_fpl != '0))
        else $error("open message with no payload due");

    // with no message open the frame position rests at a frame boundary
    a_closed_at_boundary : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_item_valid && !r_open) |-> (r_pos == '0))
        else $error("closed message left mid-frame");

    // the beat that closes a message is the final byte of a frame
    a_close_on_frame_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end && !r_open) |-> o_frame_end)
        else $error("message closed without finishing its frame");

    // the item register is only released on its last beat or a drop
    a_release_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_valid && !o_stall) |-> (item_drop || (beat_last && advance)))
        else $error("item released before its last beat");
`endif

endmodule

// ----- sim/message_fragmenter_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// message_fragmenter_tb - self-checking bench for the message fragmenter
// Queue-fed driver and clocked monitor with random idle and stall. A local
// frame predictor builds the expected frame bytes for every accepted beat.
// ============================================================================
module message_fragmenter_tb;
    import mfrag_pkg::*;

    localparam int FRAME          = FRAME_BYTES_DEF;
    localparam int RANDOM_ITEMS   = 450;
    localparam int QUIET_LIMIT    = 2000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 2 * FRAME + 8;

    typedef struct packed {
        bit         action;
        logic [15:0] length;
        logic [7:0]  payload;
    } t_msg_beat;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       run_end;
    } t_frame_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [15:0] i_message_length;
    logic [7:0]  i_payload_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_frame_byte;
    logic        o_frame_end;
    logic        o_run_end;

    message_fragmenter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_message_length (i_message_length),
        .i_payload_byte   (i_payload_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_byte     (o_frame_byte),
        .o_frame_end      (o_frame_end),
        .o_run_end        (o_run_end)
    );

    // beats waiting to be offered, and frame bytes the block still owes us
    t_msg_beat   pending[$];
    t_frame_beat frames_due[$];

    int  total_items;
    int  beats_in;
    int  error_count;
    int  quiet_cycles;
    bit  offer_live;        // a beat is on the input port and not yet taken
    bit  got_beat;
    t_msg_beat   cur_item;
    t_frame_beat seen, want;

    // ------------------------------------------------------------------------
    // Frame predictor state
    // ------------------------------------------------------------------------
    bit          frag_open;         // a message is in progress
    int unsigned frag_bytes_left;   // payload bytes still owed by the message
    int unsigned frag_frames_left;  // frames not yet begun
    int unsigned frag_pos;          // bytes already out in the current frame
    int unsigned frag_room;         // payload bytes still due in this frame
    int          burst_len;         // frame bytes caused by the current beat

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task note_error(input string msg);
        begin
            $display("ERROR @%0t: %s", $time, msg);
            error_count++;
        end
    endtask

    // one frame byte out; a byte that completes the frame carries frame_end
    task emit_byte(input int unsigned value);
        t_frame_beat fb;
        begin
            frag_pos++;
            fb.frame_byte = 8'(value);
            fb.frame_end  = (frag_pos >= FRAME);
            fb.run_end    = 1'b0;
            if (frag_pos >= FRAME)
                frag_pos = 0;
            frames_due.push_back(fb);
            burst_len++;
        end
    endtask

    task pad_out_frame;
        begin
            while (frag_pos != 0)
                emit_byte(0);
        end
    endtask

    // Close out full frames. Opens the next frame, which is either a middle
    // frame or the last one with its length byte; closes the message once
    // the last frame is done. An empty last frame falls straight through.
    task advance_frames;
        begin
            while (frag_open && frag_room == 0) begin
                pad_out_frame();
                if (frag_frames_left == 0) begin
                    frag_open       = 1'b0;
                    frag_bytes_left = 0;
                    break;
                end
                frag_frames_left--;
                if (frag_frames_left == 0) begin
                    emit_byte(frag_bytes_left);
                    frag_room = frag_bytes_left;
                end else begin
                    frag_room = FRAME;
                end
            end
        end
    endtask

    task predict_frames(input bit act, input logic [15:0] len_in, input logic [7:0] data);
        int unsigned len, n_frames, first_len;
        t_frame_beat fb;
        begin
            burst_len = 0;
            if (act == ACT_START) begin
                len = len_in;
                // a start on an open message finishes the frame in flight
                if (frag_open)
                    pad_out_frame();
                frag_pos = 0;
                if (len <= FRAME - HEAD_BYTES) begin
                    n_frames  = 1;
                    first_len = len;
                end else begin
                    n_frames  = (len + HEAD_BYTES + TAIL_BYTES + FRAME - 1) / FRAME;
                    first_len = FRAME - HEAD_BYTES;
                end
                emit_byte(n_frames >> 24);
                emit_byte(n_frames >> 16);
                emit_byte(n_frames >> 8);
                emit_byte(n_frames);
                emit_byte(first_len);
                frag_open        = 1'b1;
                frag_bytes_left  = len;
                frag_frames_left = n_frames - 1;
                frag_room        = first_len;
                advance_frames();
            end else if (frag_open) begin
                emit_byte(data);
                frag_bytes_left--;
                frag_room--;
                advance_frames();
            end
            // tag the final byte of this beat's run
            if (burst_len > 0) begin
                fb = frames_due.pop_back();
                fb.run_end = 1'b1;
                frames_due.push_back(fb);
            end
        end
    endtask

    // idle percentage per side, stepped through three phases of the run
    function automatic int idle_pct(input bit receiver);
        begin
            if (beats_in < total_items / 3)
                idle_pct = receiver ? 45 : 26;
            else if (beats_in < 2 * total_items / 3)
                idle_pct = receiver ? 26 : 45;
            else
                idle_pct = 0;
        end
    endfunction

    task queue_start(input int unsigned len);
        t_msg_beat b;
        begin
            b.action  = ACT_START;
            b.length  = 16'(len);
            b.payload = 8'($urandom);
            pending.push_back(b);
        end
    endtask

    task queue_data(input logic [7:0] value);
        t_msg_beat b;
        begin
            b.action  = ACT_DATA;
            b.length  = 16'($urandom);
            b.payload = value;
            pending.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sampling at the rising edge: input beat -> prediction, output beat ->
    // compare against the oldest expected frame byte. Also the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            got_beat = 1'b0;
            if (i_valid && !o_stall) begin
                predict_frames(i_action, i_message_length, i_payload_byte);
                offer_live = 1'b0;
                beats_in++;
                got_beat = 1'b1;
            end
            if (o_valid && !i_stall) begin
                got_beat = 1'b1;
                seen.frame_byte = o_frame_byte;
                seen.frame_end  = o_frame_end;
                seen.run_end    = o_run_end;
                if (frames_due.size() == 0) begin
                    note_error($sformatf("unexpected frame beat byte=%02h end=%b run=%b",
                                         seen.frame_byte, seen.frame_end, seen.run_end));
                end else begin
                    want = frames_due.pop_front();
                    if (seen.frame_byte !== want.frame_byte)
                        note_error($sformatf("frame_byte %02h, expected %02h",
                                             seen.frame_byte, want.frame_byte));
                    if (seen.frame_end !== want.frame_end)
                        note_error($sformatf("frame_end %b, expected %b",
                                             seen.frame_end, want.frame_end));
                    if (seen.run_end !== want.run_end)
                        note_error($sformatf("run_end %b, expected %b",
                                             seen.run_end, want.run_end));
                end
            end
            quiet_cycles = got_beat ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("message_fragmenter_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving at the falling edge: offer the next pending beat unless the
    // sender idles this cycle; hold an offered beat until it is taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!offer_live) begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    cur_item = pending.pop_front();
                    i_action         <= cur_item.action;
                    i_message_length <= cur_item.length;
                    i_payload_byte   <= cur_item.payload;
                    i_valid          <= 1'b1;
                    offer_live = 1'b1;
                end else begin
                    // idle: junk on the data lines, valid low
                    i_valid          <= 1'b0;
                    i_action         <= 1'($urandom_range(1));
                    i_message_length <= 16'($urandom);
                    i_payload_byte   <= 8'($urandom);
                end
            end
            i_stall <= ($urandom_range(99) < idle_pct(1'b1));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned len, sent, pick, cap, k;
        int directed_count;

        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_action         = ACT_START;
        i_message_length = '0;
        i_payload_byte   = '0;
        frag_open        = 1'b0;
        frag_bytes_left  = 0;
        frag_frames_left = 0;
        frag_pos         = 0;
        frag_room        = 0;
        beats_in         = 0;
        error_count      = 0;
        quiet_cycles     = 0;
        offer_live       = 1'b0;

        // --- directed beats ---
        queue_data(8'hA5);          // no message open: swallowed
        queue_start(0);             // empty message, closes on its start
        queue_data(8'h3C);          // after close: swallowed
        queue_start(3);             // short single frame, completes
        queue_data(8'h00);
        queue_data(8'hFF);
        queue_data(8'h81);
        queue_start(16'hFFFF);      // longest message, cut off after two bytes
        queue_data(8'h7E);
        queue_data(8'h01);
        queue_start(28);            // start while open: pads the first frame
        queue_start(27);            // start right after a header
        for (k = 0; k < 27; k++) begin
            if (k < 3) begin
                queue_data(8'hC3);
            end else begin
                queue_start(27);    // single frame again; cuts the open one off after three bytes
                k = 27;
            end
        end
        directed_count = pending.size();

        // --- random messages, mostly well formed ---
        while (pending.size() < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_data(8'($urandom));       // stray payload
            end else begin
                pick = $urandom_range(99);
                if (pick < 35)
                    len = $urandom_range(27);
                else if (pick < 60)
                    len = $urandom_range(130, 28);
                else if (pick < 85)
                    len = 32 * $urandom_range(3) + 26 + $urandom_range(2); // frame edges
                else
                    len = 16'($urandom);
                sent = len;
                if (len > 130 || $urandom_range(99) < 15) begin
                    // truncated; sometimes right on a frame edge
                    cap  = (len < 70) ? len : 70;
                    sent = (len >= 59 && $urandom_range(2) == 0) ? 59 : $urandom_range(cap);
                end
                queue_start(len);
                for (k = 0; k < sent; k++)
                    queue_data(8'($urandom));
            end
        end
        total_items = pending.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || offer_live)
            @(negedge i_clk);
        while (frames_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("message_fragmenter_tb: PASS");
        else
            $display("message_fragmenter_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/mfrag_pkg.sv
rtl/core/message_fragmenter.sv
sim/message_fragmenter_tb.sv
